[design/signed_integer_to_text_any_radix_macros.svh]
// assertion macros shared by the radix text converter modules
// no dependencies; assertions compile away when SYNTH is defined
`ifndef SIGNED_INTEGER_TO_TEXT_ANY_RADIX_MACROS_SVH
`define SIGNED_INTEGER_TO_TEXT_ANY_RADIX_MACROS_SVH
`ifndef SYNTH
// same-cycle implication, disabled during reset
`define SITAR_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("sitar assertion failed");
// next-cycle implication, disabled during reset
`define SITAR_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("sitar assertion failed");
`else
`define SITAR_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define SITAR_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

[design/sitar_pkg.sv]
// shared constants, types and the digit encoder for the radix text converter
// no dependencies
`timescale 1ns / 1ps

package sitar_pkg;

  // input and register widths
  localparam int VALUE_BITS = 32;
  localparam int RADIX_BITS = 6;
  localparam int DIGIT_BITS = RADIX_BITS;
  localparam int CHAR_BITS  = 7;

  // radix register bounds and reset value
  localparam logic [RADIX_BITS-1:0] RADIX_RESET = RADIX_BITS'(10);
  localparam logic [RADIX_BITS-1:0] RADIX_MIN   = RADIX_BITS'(2);
  localparam logic [RADIX_BITS-1:0] RADIX_MAX   = RADIX_BITS'(36);

  // divider: quotient bits resolved per cycle, cycles per division
  localparam int STEP_BITS     = 8;
  localparam int DIV_CYCLES    = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int WORK_BITS     = DIV_CYCLES * STEP_BITS;
  localparam int STEP_CNT_BITS = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  // digit stack holds every digit of a radix 2 conversion
  localparam int STACK_DEPTH = VALUE_BITS;
  localparam int CNT_BITS    = $clog2(STACK_DEPTH + 1);

  // ascii codes
  localparam logic [CHAR_BITS-1:0] CHAR_ZERO    = 7'h30;
  localparam logic [CHAR_BITS-1:0] CHAR_LOWER_A = 7'h61;
  localparam logic [CHAR_BITS-1:0] CHAR_MINUS   = 7'h2d;
  localparam logic [CHAR_BITS-1:0] CHAR_NONE    = 7'h00;
  localparam logic [DIGIT_BITS-1:0] DECIMAL_DIGITS = DIGIT_BITS'(10);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_EMIT,
    ST_EMPTY
  } state_t;

  typedef enum logic [1:0] {
    EMIT_SIGN,
    EMIT_DIGIT,
    EMIT_EMPTY
  } emit_sel_t;

  typedef struct packed {
    logic      load;
    logic      div_step;
    logic      emit;
    emit_sel_t emit_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic radix_ok;
    logic neg;
    logic div_last;
    logic quot_zero;
    logic stack_last;
    logic stack_full;
    logic out_free;
  } dp_status_t;

  // digit value to ascii, 0-9 then lowercase a-z
  function automatic logic [CHAR_BITS-1:0] digit_char(input logic [DIGIT_BITS-1:0] d);
    if (d < DECIMAL_DIGITS) begin
      return CHAR_ZERO + CHAR_BITS'(d);
    end else begin
      return CHAR_LOWER_A + CHAR_BITS'(d - DECIMAL_DIGITS);
    end
  endfunction

endpackage

[design/sitar_if.sv]
// valid/ready channel interfaces for value requests, text results and radix writes
// depends on sitar_pkg for field widths
`timescale 1ns / 1ps

interface sitar_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [sitar_pkg::VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sitar_out_if;
  logic                           valid;
  logic                           ready;
  logic [sitar_pkg::CHAR_BITS-1:0] character;
  logic                           last;
  logic                           empty_res;

  modport source (output valid, output character, output last, output empty_res,
                  input ready);
  modport sink   (input valid, input character, input last, input empty_res,
                  output ready);
endinterface

interface sitar_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [sitar_pkg::RADIX_BITS-1:0] radix;

  modport source (output valid, output radix, input ready);
  modport sink   (input valid, input radix, output ready);
endinterface

[design/sitar_ctrl.sv]
// control state machine: sequences load, division, sign and digit output, or the empty result for an invalid radix
// depends on sitar_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "signed_integer_to_text_any_radix_macros.svh"

module sitar_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sitar_pkg::dp_status_t status,
  output sitar_pkg::dp_cmd_t    cmd
);
  import sitar_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.emit_sel = EMIT_DIGIT;
    in_ready     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = status.radix_ok ? ST_DIV : ST_EMPTY;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last && (status.quot_zero || status.stack_full)) begin
          state_nxt = status.neg ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (status.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EMIT_SIGN;
          state_nxt    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EMIT_DIGIT;
          if (status.stack_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_EMPTY: begin
        if (status.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EMIT_EMPTY;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // checks
  `SITAR_ASSERT_IMP(a_emit_has_room, clk, rst_n, cmd.emit, status.out_free)
  `SITAR_ASSERT_NXT(a_final_digit_idles, clk, rst_n, state_r == ST_EMIT && cmd.emit && status.stack_last, state_r == ST_IDLE)
  `SITAR_ASSERT_NXT(a_more_digits_stay, clk, rst_n, cmd.div_step && status.div_last && !status.quot_zero && !status.stack_full, state_r == ST_DIV)

endmodule

[design/sitar_dp.sv]
// datapath: radix register, shared divider, digit stack and output register
// depends on sitar_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "signed_integer_to_text_any_radix_macros.svh"

module sitar_dp (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  sitar_pkg::dp_cmd_t                      cmd,
  output sitar_pkg::dp_status_t                   status,
  input  logic signed [sitar_pkg::VALUE_BITS-1:0] in_value,
  input  logic                                    cfg_valid,
  input  logic [sitar_pkg::RADIX_BITS-1:0]        cfg_radix,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [sitar_pkg::CHAR_BITS-1:0]         out_character,
  output logic                                    out_last,
  output logic                                    out_empty_res
);
  import sitar_pkg::*;

  logic [RADIX_BITS-1:0]    radix_r;
  logic                     neg_r;
  logic [WORK_BITS-1:0]     work_r, work_nxt;
  logic [DIGIT_BITS-1:0]    rem_r, rem_nxt;
  logic [STEP_CNT_BITS-1:0] step_r;
  logic [DIGIT_BITS-1:0]    stk_r [STACK_DEPTH];
  logic [CNT_BITS-1:0]      cnt_r;
  logic                     out_valid_r;
  logic [CHAR_BITS-1:0]     char_r;
  logic                     last_r;
  logic                     empty_r;

  logic [VALUE_BITS-1:0]    value_u;
  logic [VALUE_BITS-1:0]    mag;
  logic [STEP_BITS-1:0]     qbyte;
  logic [DIGIT_BITS-1:0]    rem_w;
  logic [DIGIT_BITS:0]      trial;
  logic                     push;
  logic                     pop;

  // magnitude of the incoming value
  always_comb begin
    value_u = in_value;
    mag     = value_u[VALUE_BITS-1] ? (~value_u + 1'b1) : value_u;
  end

  // one divider slice: STEP_BITS restoring steps against the radix
  always_comb begin
    rem_w = rem_r;
    trial = '0;
    qbyte = '0;
    for (int i = STEP_BITS - 1; i >= 0; i--) begin
      trial = {rem_w, work_r[WORK_BITS-STEP_BITS+i]};
      if (trial >= {1'b0, radix_r}) begin
        qbyte[i] = 1'b1;
        rem_w    = DIGIT_BITS'(trial - {1'b0, radix_r});
      end else begin
        rem_w    = trial[DIGIT_BITS-1:0];
      end
    end
    rem_nxt  = rem_w;
    work_nxt = WORK_BITS'({work_r, qbyte});
  end

  assign push = cmd.div_step && status.div_last;
  assign pop  = cmd.emit && (cmd.emit_sel == EMIT_DIGIT);

  // status back to the controller
  always_comb begin
    status.radix_ok   = (radix_r >= RADIX_MIN) && (radix_r <= RADIX_MAX);
    status.neg        = neg_r;
    status.div_last   = (step_r == STEP_CNT_BITS'(DIV_CYCLES - 1));
    status.quot_zero  = (work_nxt == '0);
    status.stack_last = (cnt_r == CNT_BITS'(1));
    status.stack_full = (cnt_r == CNT_BITS'(STACK_DEPTH - 1));
    status.out_free   = !out_valid_r || out_ready;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r     <= RADIX_RESET;
      step_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        radix_r <= cfg_radix;
      end
      if (cmd.load) begin
        step_r <= '0;
      end else if (cmd.div_step) begin
        step_r <= status.div_last ? '0 : step_r + 1'b1;
      end
      if (cmd.load) begin
        cnt_r <= '0;
      end else if (push) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // divider working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      work_r <= WORK_BITS'(mag);
      rem_r  <= '0;
      neg_r  <= value_u[VALUE_BITS-1];
    end else if (cmd.div_step) begin
      work_r <= work_nxt;
      rem_r  <= status.div_last ? '0 : rem_nxt;
    end
  end

  // digit stack, least significant digit pushed first
  always_ff @(posedge clk) begin
    if (push) begin
      stk_r[0] <= rem_nxt;
      for (int i = 1; i < STACK_DEPTH; i++) begin
        stk_r[i] <= stk_r[i-1];
      end
    end else if (pop) begin
      for (int i = 0; i < STACK_DEPTH - 1; i++) begin
        stk_r[i] <= stk_r[i+1];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      unique case (cmd.emit_sel)
        EMIT_SIGN: begin
          char_r  <= CHAR_MINUS;
          last_r  <= 1'b0;
          empty_r <= 1'b0;
        end
        EMIT_DIGIT: begin
          char_r  <= digit_char(stk_r[0]);
          last_r  <= status.stack_last;
          empty_r <= 1'b0;
        end
        EMIT_EMPTY: begin
          char_r  <= CHAR_NONE;
          last_r  <= 1'b1;
          empty_r <= 1'b1;
        end
        default: begin
          char_r  <= CHAR_NONE;
          last_r  <= 1'b1;
          empty_r <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_character = char_r;
  assign out_last      = last_r;
  assign out_empty_res = empty_r;

  // checks
  `SITAR_ASSERT_IMP(a_no_pop_empty, clk, rst_n, pop, cnt_r != '0)
  `SITAR_ASSERT_IMP(a_no_push_full, clk, rst_n, push, cnt_r != CNT_BITS'(STACK_DEPTH))
  `SITAR_ASSERT_NXT(a_last_digit_marked, clk, rst_n, pop && status.stack_last, out_last && !out_empty_res)

endmodule

[design/signed_integer_to_text_any_radix.sv]
// top level: signed integer to ascii text in a programmable radix
// depends on sitar_pkg, sitar_if, sitar_ctrl and sitar_dp
`timescale 1ns / 1ps
//
// usage
//   in_chan   : one request per integer (value, two's complement)
//   out_chan  : one ascii character per transfer, most significant first,
//               '-' first for negative values, last set on the final one;
//               an invalid radix (outside 2..36) gives one transfer with
//               character 0, last and empty_res set
//   cfg_chan  : radix write, always ready; write only while no request is in flight
// timing
//   a request is accepted only in the idle state, one at a time
//   each digit is one division in the shared divider, which resolves
//   8 quotient bits per cycle; then sign and digits leave one per cycle
//   while the output channel is not stalled
// reset: radix returns to 10, stack and output register are emptied
// stall: a held result stays in the output register and the sequencer waits;
//   the next request is taken while the final character still waits
module signed_integer_to_text_any_radix (
  input  logic           clk,
  input  logic           rst_n,
  sitar_in_if.sink       in_chan,
  sitar_out_if.source    out_chan,
  sitar_cfg_if.sink      cfg_chan
);
  import sitar_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready_w;

  // handshake readies
  assign in_chan.ready  = in_ready_w;
  assign cfg_chan.ready = 1'b1;

  // controller
  sitar_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready_w),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath
  sitar_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .in_value      (in_chan.value),
    .cfg_valid     (cfg_chan.valid),
    .cfg_radix     (cfg_chan.radix),
    .out_valid     (out_chan.valid),
    .out_ready     (out_chan.ready),
    .out_character (out_chan.character),
    .out_last      (out_chan.last),
    .out_empty_res (out_chan.empty_res)
  );

endmodule
